>>> sv/fgbb_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and coordinate helpers for the foreground bounding box unit.
package fgbb_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W   = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
    localparam int ROW_W   = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int COORD_W = 13;
    localparam int CHAN_W  = 8;

    localparam int WHITE_THRESHOLD_RESET = 240;

    typedef logic [CHAN_W-1:0]         chan_t;
    typedef logic [COL_W-1:0]          col_t;
    typedef logic [ROW_W-1:0]          row_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    localparam col_t   COL_LAST   = col_t'(MAX_WIDTH - 1);
    localparam row_t   ROW_LAST   = row_t'(MAX_HEIGHT - 1);
    localparam coord_t COORD_NONE = '1;

    // Control flags of one classified pixel handed to the tracker.
    typedef struct packed {
        logic foreground;
        logic end_of_line;
        logic end_of_frame;
    } pixel_ctl_t;

    // Bring a column index to the 13-bit output field, masking wide indexes.
    function automatic coord_t col_to_coord(col_t c);
        logic [COL_W+COORD_W-1:0] wide;
        begin
            wide = {{COORD_W{1'b0}}, c};
            return coord_t'(wide[COORD_W-1:0]);
        end
    endfunction

    // Bring a row index to the 13-bit output field, masking wide indexes.
    function automatic coord_t row_to_coord(row_t r);
        logic [ROW_W+COORD_W-1:0] wide;
        begin
            wide = {{COORD_W{1'b0}}, r};
            return coord_t'(wide[COORD_W-1:0]);
        end
    endfunction

endpackage

>>> sv/fgbb_input_stage.sv
`timescale 1ns / 1ps
// Input register and white-threshold classification of each pixel.
module fgbb_input_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fgbb_pkg::chan_t      pixel_blue,
    input  fgbb_pkg::chan_t      pixel_green,
    input  fgbb_pkg::chan_t      pixel_red,
    input  logic                 end_of_line,
    input  logic                 end_of_frame,
    input  fgbb_pkg::chan_t      white_threshold,
    output logic                 px_valid,
    input  logic                 px_ready,
    output fgbb_pkg::pixel_ctl_t px_ctl
);

    logic            valid_reg;
    fgbb_pkg::chan_t blue_reg;
    fgbb_pkg::chan_t green_reg;
    fgbb_pkg::chan_t red_reg;
    logic            eol_reg;
    logic            eof_reg;
    logic            white;

    // The register takes a new item whenever it is empty or draining.
    assign in_ready = !valid_reg || px_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            blue_reg  <= pixel_blue;
            green_reg <= pixel_green;
            red_reg   <= pixel_red;
            eol_reg   <= end_of_line;
            eof_reg   <= end_of_frame;
        end
    end

    // A pixel is background only when all three channels reach the threshold.
    assign white = (blue_reg >= white_threshold) && (green_reg >= white_threshold)
                   && (red_reg >= white_threshold);

    assign px_valid            = valid_reg;
    assign px_ctl.foreground   = !white;
    assign px_ctl.end_of_line  = eol_reg;
    assign px_ctl.end_of_frame = eof_reg;

endmodule

>>> sv/fgbb_tracker.sv
`timescale 1ns / 1ps
// Row and column counters, bounds tracking and the result register.
module fgbb_tracker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 px_valid,
    output logic                 px_ready,
    input  fgbb_pkg::pixel_ctl_t px_ctl,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fgbb_pkg::coord_t     top_row,
    output fgbb_pkg::coord_t     bottom_row,
    output fgbb_pkg::coord_t     left_column,
    output fgbb_pkg::coord_t     right_column,
    output logic                 found
);

    fgbb_pkg::col_t   col_reg;
    fgbb_pkg::row_t   row_reg;
    fgbb_pkg::row_t   top_reg;
    fgbb_pkg::row_t   bottom_reg;
    fgbb_pkg::col_t   left_reg;
    fgbb_pkg::col_t   right_reg;
    logic             found_reg;

    fgbb_pkg::row_t   top_upd;
    fgbb_pkg::row_t   bottom_upd;
    fgbb_pkg::col_t   left_upd;
    fgbb_pkg::col_t   right_upd;
    logic             found_upd;

    logic             out_valid_reg;
    fgbb_pkg::coord_t top_out_reg;
    fgbb_pkg::coord_t bottom_out_reg;
    fgbb_pkg::coord_t left_out_reg;
    fgbb_pkg::coord_t right_out_reg;
    logic             found_out_reg;

    logic             accept;

    // Only an end-of-frame item needs room in the result register.
    assign px_ready = !px_ctl.end_of_frame || !out_valid_reg || out_ready;
    assign accept   = px_valid && px_ready;

    always_comb
    begin
        top_upd    = top_reg;
        bottom_upd = bottom_reg;
        left_upd   = left_reg;
        right_upd  = right_reg;
        found_upd  = found_reg || px_ctl.foreground;
        if (px_ctl.foreground)
        begin
            if (!found_reg)
            begin
                top_upd = row_reg;
            end
            bottom_upd = row_reg;
            if (!found_reg || (col_reg < left_reg))
            begin
                left_upd = col_reg;
            end
            if (!found_reg || (col_reg > right_reg))
            begin
                right_upd = col_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            top_reg    <= '0;
            bottom_reg <= '0;
            left_reg   <= '0;
            right_reg  <= '0;
            found_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (px_ctl.end_of_frame)
            begin
                col_reg    <= '0;
                row_reg    <= '0;
                top_reg    <= '0;
                bottom_reg <= '0;
                left_reg   <= '0;
                right_reg  <= '0;
                found_reg  <= 1'b0;
            end
            else
            begin
                top_reg    <= top_upd;
                bottom_reg <= bottom_upd;
                left_reg   <= left_upd;
                right_reg  <= right_upd;
                found_reg  <= found_upd;
                if (px_ctl.end_of_line)
                begin
                    col_reg <= '0;
                    if (row_reg != fgbb_pkg::ROW_LAST)
                    begin
                        row_reg <= row_reg + 1'b1;
                    end
                end
                else if (col_reg != fgbb_pkg::COL_LAST)
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept && px_ctl.end_of_frame)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && px_ctl.end_of_frame)
        begin
            found_out_reg  <= found_upd;
            top_out_reg    <= found_upd ? fgbb_pkg::row_to_coord(top_upd)
                                        : fgbb_pkg::COORD_NONE;
            bottom_out_reg <= found_upd ? fgbb_pkg::row_to_coord(bottom_upd)
                                        : fgbb_pkg::COORD_NONE;
            left_out_reg   <= found_upd ? fgbb_pkg::col_to_coord(left_upd)
                                        : fgbb_pkg::COORD_NONE;
            right_out_reg  <= found_upd ? fgbb_pkg::col_to_coord(right_upd)
                                        : fgbb_pkg::COORD_NONE;
        end
    end

    assign out_valid    = out_valid_reg;
    assign top_row      = top_out_reg;
    assign bottom_row   = bottom_out_reg;
    assign left_column  = left_out_reg;
    assign right_column = right_out_reg;
    assign found        = found_out_reg;

`ifndef ASSERT_OFF
    a_rows_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (top_reg <= bottom_reg))
        else $error("top bound below bottom bound");

    a_cols_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (left_reg <= right_reg))
        else $error("left bound right of right bound");

    a_bottom_seen: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (bottom_reg <= row_reg))
        else $error("bottom bound beyond current row");

    a_frame_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && px_ctl.end_of_frame) |=> out_valid_reg)
        else $error("end of frame gave no result");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && px_ctl.end_of_frame) |=>
            (!found_reg && (row_reg == '0) && (col_reg == '0)))
        else $error("frame state not cleared after end of frame");
`endif

endmodule

>>> sv/foreground_bounding_box_unit.sv
`timescale 1ns / 1ps
// Top level of the foreground bounding box unit.
//
// The unit watches a raster stream of BGR pixels, one item per pixel, and
// reports the smallest box of rows and columns that holds every foreground
// pixel of a frame. A pixel is foreground unless its blue, green and red
// channels are all at or above white_threshold, which is written through
// cfg_write_enable and cfg_write_data and resets to 240. On the item marked
// end_of_frame the unit counts that pixel, presents one result with the
// first and last foreground rows and columns (all -1 with found low when the
// frame held no foreground), and starts the next frame from row and column
// zero; end_of_frame wins when both marks are set. Rows may differ in length.
// Column and row indexes saturate at MAX_WIDTH-1 and MAX_HEIGHT-1. Each item
// passes through an input register, where it is classified, and then updates
// the counters and bounds while the result lands in an output register. When
// the output register is free, the tracker accepts the end-of-frame item from
// the input register and out_valid rises in the cycle after. The unit takes
// one item every cycle; the input stalls only while an end-of-frame item sits
// in the input register waiting for the previous result to leave the output
// register.
module foreground_bounding_box_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_enable,
    input  fgbb_pkg::chan_t  cfg_write_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  fgbb_pkg::chan_t  pixel_blue,
    input  fgbb_pkg::chan_t  pixel_green,
    input  fgbb_pkg::chan_t  pixel_red,
    input  logic             end_of_line,
    input  logic             end_of_frame,
    output logic             out_valid,
    input  logic             out_ready,
    output fgbb_pkg::coord_t top_row,
    output fgbb_pkg::coord_t bottom_row,
    output fgbb_pkg::coord_t left_column,
    output fgbb_pkg::coord_t right_column,
    output logic             found
);

    fgbb_pkg::chan_t      white_threshold_reg;
    logic                 px_valid;
    logic                 px_ready;
    fgbb_pkg::pixel_ctl_t px_ctl;

    // The user must write the threshold register only while no item is in flight; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_threshold_reg <= fgbb_pkg::chan_t'(fgbb_pkg::WHITE_THRESHOLD_RESET);
        end
        else if (cfg_write_enable)
        begin
            white_threshold_reg <= cfg_write_data;
        end
    end

    // First stage: register the pixel and decide whether it is foreground.
    fgbb_input_stage u_input_stage (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pixel_blue      (pixel_blue),
        .pixel_green     (pixel_green),
        .pixel_red       (pixel_red),
        .end_of_line     (end_of_line),
        .end_of_frame    (end_of_frame),
        .white_threshold (white_threshold_reg),
        .px_valid        (px_valid),
        .px_ready        (px_ready),
        .px_ctl          (px_ctl)
    );

    // Second stage: advance the raster position, grow the box, and at the
    // end of a frame load the result register and clear for the next frame.
    fgbb_tracker u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .px_valid     (px_valid),
        .px_ready     (px_ready),
        .px_ctl       (px_ctl),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .top_row      (top_row),
        .bottom_row   (bottom_row),
        .left_column  (left_column),
        .right_column (right_column),
        .found        (found)
    );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the foreground bounding box unit.
module testbench;

    // One bounding box result, in the field order of the output ports.
    typedef struct packed {
        fgbb_pkg::coord_t top;
        fgbb_pkg::coord_t bottom;
        fgbb_pkg::coord_t left;
        fgbb_pkg::coord_t right;
        logic             found;
    } box_t;

    // One row of the directed stimulus table.
    typedef struct packed {
        fgbb_pkg::chan_t blue;
        fgbb_pkg::chan_t green;
        fgbb_pkg::chan_t red;
        logic            eol;
        logic            eof;
        logic            typed;
        box_t            box;
    } dir_row_t;

    localparam box_t EMPTY_BOX  = '{fgbb_pkg::COORD_NONE, fgbb_pkg::COORD_NONE,
                                    fgbb_pkg::COORD_NONE, fgbb_pkg::COORD_NONE, 1'b0};
    localparam box_t ORIGIN_BOX = '{fgbb_pkg::coord_t'(0), fgbb_pkg::coord_t'(0),
                                    fgbb_pkg::coord_t'(0), fgbb_pkg::coord_t'(0), 1'b1};

    localparam int DIR_ROWS     = 20;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 190;
    localparam int DRAIN_CYCLES = 4;
    localparam int QUIET_LIMIT  = 2000;

    // Directed items at the reset threshold of 240. Rows with typed set carry the box
    // that can be read off directly; the rest are checked against the tracker.
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // One-pixel frames: black, pure white, exactly at threshold, one channel below.
        '{8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 1'b1, ORIGIN_BOX},
        '{8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 1'b1, EMPTY_BOX},
        '{8'd240, 8'd240, 8'd240, 1'b0, 1'b1, 1'b1, EMPTY_BOX},
        '{8'd239, 8'd240, 8'd240, 1'b0, 1'b1, 1'b1, ORIGIN_BOX},
        '{8'd240, 8'd239, 8'd240, 1'b0, 1'b1, 1'b1, ORIGIN_BOX},
        '{8'd240, 8'd240, 8'd239, 1'b0, 1'b1, 1'b1, ORIGIN_BOX},
        // Both marks on one pixel: the frame ends and the line mark is ignored.
        '{8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 1'b1, ORIGIN_BOX},
        // Ragged frame with rows of 3, 1, 5 and 2 pixels.
        '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0, EMPTY_BOX},
        '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0, EMPTY_BOX},
        '{8'd10,  8'd20,  8'd30,  1'b1, 1'b0, 1'b0, EMPTY_BOX},
        '{8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0, EMPTY_BOX},
        '{8'd5,   8'd255, 8'd255, 1'b0, 1'b0, 1'b0, EMPTY_BOX},
        '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0, EMPTY_BOX},
        '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0, EMPTY_BOX},
        '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0, EMPTY_BOX},
        '{8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0, EMPTY_BOX},
        '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0, EMPTY_BOX},
        '{8'd128, 8'd0,   8'd255, 1'b0, 1'b1, 1'b0, EMPTY_BOX},
        // A single foreground row followed by a white pixel that closes the frame.
        '{8'd255, 8'd0,   8'd0,   1'b1, 1'b0, 1'b0, EMPTY_BOX},
        '{8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 1'b0, EMPTY_BOX}
    };

    logic             clk              = 1'b0;
    logic             rst_n            = 1'b0;
    logic             cfg_write_enable = 1'b0;
    fgbb_pkg::chan_t  cfg_write_data   = '0;
    logic             in_valid         = 1'b0;
    logic             in_ready;
    fgbb_pkg::chan_t  pixel_blue       = '0;
    fgbb_pkg::chan_t  pixel_green      = '0;
    fgbb_pkg::chan_t  pixel_red        = '0;
    logic             end_of_line      = 1'b0;
    logic             end_of_frame     = 1'b0;
    logic             out_valid;
    logic             out_ready        = 1'b0;
    fgbb_pkg::coord_t top_row;
    fgbb_pkg::coord_t bottom_row;
    fgbb_pkg::coord_t left_column;
    fgbb_pkg::coord_t right_column;
    logic             found;

    // Tracker state: threshold, raster position and running bounds (-1 when empty).
    fgbb_pkg::chan_t  white_level = fgbb_pkg::chan_t'(fgbb_pkg::WHITE_THRESHOLD_RESET);
    fgbb_pkg::col_t   col_pos     = '0;
    fgbb_pkg::row_t   row_pos     = '0;
    int               top_b       = -1;
    int               bottom_b    = -1;
    int               left_b      = -1;
    int               right_b     = -1;

    box_t   expected_boxes [$];

    bit     in_idle_on         = 1'b1;
    bit     out_idle_on        = 1'b1;
    int     stall_left         = 0;
    int     quiet_cycles       = 0;
    int     mismatches         = 0;
    int     pixels_sent        = 0;
    int     boxes_checked      = 0;
    int     thresholds_written = 0;

    foreground_bounding_box_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .pixel_blue       (pixel_blue),
        .pixel_green      (pixel_green),
        .pixel_red        (pixel_red),
        .end_of_line      (end_of_line),
        .end_of_frame     (end_of_frame),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .top_row          (top_row),
        .bottom_row       (bottom_row),
        .left_column      (left_column),
        .right_column     (right_column),
        .found            (found)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void restart_frame();
        col_pos  = '0;
        row_pos  = '0;
        top_b    = -1;
        bottom_b = -1;
        left_b   = -1;
        right_b  = -1;
    endfunction

    // Advances the tracker by one pixel; returns 1 with the finished box on end of frame.
    function automatic logic track_pixel(input fgbb_pkg::chan_t b, input fgbb_pkg::chan_t g,
                                         input fgbb_pkg::chan_t r,
                                         input logic eol, input logic eof,
                                         output box_t box);
        logic white;
        white = (b >= white_level) && (g >= white_level) && (r >= white_level);
        box   = EMPTY_BOX;
        if (!white)
        begin
            if (top_b < 0)
                top_b = int'(row_pos);
            bottom_b = int'(row_pos);
            if (left_b < 0 || int'(col_pos) < left_b)
                left_b = int'(col_pos);
            if (right_b < 0 || int'(col_pos) > right_b)
                right_b = int'(col_pos);
        end
        if (eof)
        begin
            box.top    = fgbb_pkg::coord_t'(top_b);
            box.bottom = fgbb_pkg::coord_t'(bottom_b);
            box.left   = fgbb_pkg::coord_t'(left_b);
            box.right  = fgbb_pkg::coord_t'(right_b);
            box.found  = (top_b >= 0);
            restart_frame();
            return 1'b1;
        end
        if (eol)
        begin
            col_pos = '0;
            if (row_pos != fgbb_pkg::ROW_LAST)
                row_pos++;
        end
        else if (col_pos != fgbb_pkg::COL_LAST)
        begin
            col_pos++;
        end
        return 1'b0;
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!in_idle_on || roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch at %0t ns: %s is %0d, expected %0d", $time, what, got, want);
    endtask

    // Presents one item from a falling edge and holds it until it is accepted.
    task automatic send_pixel(input fgbb_pkg::chan_t b, input fgbb_pkg::chan_t g,
                              input fgbb_pkg::chan_t r,
                              input logic eol, input logic eof,
                              input logic typed, input box_t typed_box);
        int   gap;
        box_t box;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_blue   = b;
        pixel_green  = g;
        pixel_red    = r;
        end_of_line  = eol;
        end_of_frame = eof;
        in_valid     = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pixels_sent++;
        if (track_pixel(b, g, r, eol, eof, box))
            expected_boxes.push_back(typed ? typed_box : box);
        @(negedge clk);
    endtask

    // White pixels get every channel at or above the threshold; foreground pixels pull
    // one channel below it. One pixel in ten has fully random channels.
    task automatic send_random_pixel(input bit fg, input logic eol, input logic eof);
        fgbb_pkg::chan_t ch [3];
        int              low_idx;
        for (int i = 0; i < 3; i++)
            ch[i] = fgbb_pkg::chan_t'($urandom_range(int'(white_level), 255));
        if (fg && white_level != 0)
        begin
            low_idx     = $urandom_range(0, 2);
            ch[low_idx] = fgbb_pkg::chan_t'($urandom_range(0, int'(white_level) - 1));
        end
        if ($urandom_range(0, 9) == 0)
        begin
            for (int i = 0; i < 3; i++)
                ch[i] = fgbb_pkg::chan_t'($urandom);
        end
        send_pixel(ch[0], ch[1], ch[2], eol, eof, 1'b0, EMPTY_BOX);
    endtask

    // A well-formed frame; ragged frames draw each row length on its own.
    task automatic send_frame(input int cols, input int rows, input int fg_pct,
                              input bit ragged);
        int   len;
        logic last_row;
        for (int y = 0; y < rows; y++)
        begin
            len      = ragged ? $urandom_range(1, 2 * cols) : cols;
            last_row = (y == rows - 1);
            for (int x = 0; x < len; x++)
                send_random_pixel($urandom_range(0, 99) < fg_pct,
                                  (x == len - 1) && (!last_row || $urandom_range(0, 1) == 1),
                                  last_row && (x == len - 1));
        end
    endtask

    // Items with random marks, so frames and rows end anywhere.
    task automatic send_noise(input int count);
        for (int i = 0; i < count; i++)
            send_random_pixel($urandom_range(0, 1) == 1, $urandom_range(0, 2) == 0,
                              $urandom_range(0, 9) == 0);
    endtask

    // The threshold only changes once every result is out and the pipeline has drained.
    task automatic write_threshold(input fgbb_pkg::chan_t level);
        in_valid = 1'b0;
        while (expected_boxes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_write_enable = 1'b1;
        cfg_write_data   = level;
        @(negedge clk);
        cfg_write_enable = 1'b0;
        white_level      = level;
        thresholds_written++;
    endtask

    // Result side: random stalls, mostly short.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready = 1'b0;
            stall_left--;
        end
        else if (rst_n && out_idle_on && $urandom_range(0, 3) == 0)
        begin
            out_ready  = 1'b0;
            stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                       : $urandom_range(7, 39);
        end
        else
        begin
            out_ready = 1'b1;
        end
    end

    // Each accepted result is compared with the oldest expected box.
    always @(posedge clk)
    begin
        box_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_boxes.size() == 0)
            begin
                report_mismatch("result with nothing expected, found", int'(found), 0);
            end
            else
            begin
                want = expected_boxes.pop_front();
                boxes_checked++;
                if (top_row !== want.top)
                    report_mismatch("top_row", int'(top_row), int'(want.top));
                if (bottom_row !== want.bottom)
                    report_mismatch("bottom_row", int'(bottom_row), int'(want.bottom));
                if (left_column !== want.left)
                    report_mismatch("left_column", int'(left_column), int'(want.left));
                if (right_column !== want.right)
                    report_mismatch("right_column", int'(right_column), int'(want.right));
                if (found !== want.found)
                    report_mismatch("found", int'(found), int'(want.found));
            end
        end
    end

    // Watchdog: too many cycles without a handshake on either side ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("no handshake for %0d cycles", QUIET_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        fgbb_pkg::chan_t plan [PHASES];
        int              phase_start;
        int              cols;
        int              rows;
        int              fg_pct;

        plan = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd200, 8'd0, 8'd254, 8'd240};
        plan[5] = fgbb_pkg::chan_t'($urandom_range(2, 253));

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_pixel(DIRECTED[i].blue, DIRECTED[i].green, DIRECTED[i].red,
                       DIRECTED[i].eol, DIRECTED[i].eof, DIRECTED[i].typed, DIRECTED[i].box);

        for (int p = 0; p < PHASES; p++)
        begin
            write_threshold(plan[p]);
            phase_start = pixels_sent;
            while (pixels_sent - phase_start < PHASE_ITEMS)
            begin
                in_idle_on  = ($urandom_range(0, 3) != 0);
                out_idle_on = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 9) == 0)
                begin
                    send_noise($urandom_range(5, 20));
                end
                else
                begin
                    cols = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 30)
                                                       : $urandom_range(1, 8);
                    rows = $urandom_range(1, 6);
                    case ($urandom_range(0, 3))
                        0:       fg_pct = 0;
                        1:       fg_pct = 3;
                        2:       fg_pct = 20;
                        default: fg_pct = 60;
                    endcase
                    send_frame(cols, rows, fg_pct, $urandom_range(0, 2) == 0);
                end
            end
        end

        in_valid = 1'b0;
        while (expected_boxes.size() != 0)
            @(negedge clk);
        repeat (3 * DRAIN_CYCLES) @(negedge clk);

        $display("sent %0d pixels, checked %0d frame boxes over %0d threshold settings",
                 pixels_sent, boxes_checked, thresholds_written);
        $display("%0d mismatches, %0d boxes still outstanding",
                 mismatches, expected_boxes.size());
        if (mismatches == 0 && expected_boxes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
sv/fgbb_pkg.sv
sv/fgbb_input_stage.sv
sv/fgbb_tracker.sv
sv/foreground_bounding_box_unit.sv
tb/testbench.sv
